// File: rtl/resident_page_hash_set_assert.svh
// ----------------------------------------------------------------------------
// Resident page hash set assertion macros
// Shared property templates for the concurrent checks of the hash set.
// ----------------------------------------------------------------------------
`ifndef RESIDENT_PAGE_HASH_SET_ASSERT_SVH
`define RESIDENT_PAGE_HASH_SET_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and muted while rst_ni is low.
`define RPHS_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and muted while rst_ni is low.
`define RPHS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/rphs_pkg.sv
// ----------------------------------------------------------------------------
// Resident page hash set package
// Request kinds, slot codes and mixing constants shared by the hash set.
// ----------------------------------------------------------------------------
package rphs_pkg;

  typedef enum logic [1:0] {
    KIND_INSERT   = 2'd0,
    KIND_CONTAINS = 2'd1,
    KIND_REMOVE   = 2'd2,
    KIND_SCAN     = 2'd3
  } kind_e;

  localparam logic [63:0] SLOT_EMPTY = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SLOT_TOMB  = 64'hFFFF_FFFF_FFFF_FFFE;

  localparam logic [63:0] MIX_MUL  = 64'hc6a4_a793_5bd1_e995;
  localparam logic [63:0] MIX_SEED = 64'h8445_d61a_4e77_4912;
  // Initial hash state: seed xor (multiplier times eight), modulo 2^64.
  localparam logic [63:0] MIX_H0   = MIX_SEED ^ {MIX_MUL[60:0], 3'b000};
  localparam int unsigned MIX_SHIFT = 47;

endpackage

// File: rtl/rphs_ram.sv
// ----------------------------------------------------------------------------
// Resident page hash set RAM
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module rphs_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/rphs_hash.sv
// ----------------------------------------------------------------------------
// Resident page hash set home slot unit
// Murmur-style 64-bit mix on one shared 32x32 multiplier, then reduction
// of the hash to a slot index.
// ----------------------------------------------------------------------------
module rphs_hash import rphs_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [63:0]                    key_i,
  output logic                           done_o,
  output logic [$clog2(TABLE_DEPTH)-1:0] slot_o
);

  localparam int unsigned AddrW   = $clog2(TABLE_DEPTH);
  localparam bit          IsPow2  = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
  localparam logic [63:0] Pow32   = 64'h1_0000_0000;
  localparam logic [31:0] FoldMul = 32'(Pow32 % 64'(TABLE_DEPTH));
  localparam logic [31:0] Recip   = 32'(Pow32 / 64'(TABLE_DEPTH));
  localparam logic [31:0] Depth32 = 32'(TABLE_DEPTH);

  typedef enum logic [3:0] {
    HS_IDLE = 4'b0001,
    HS_MUL  = 4'b0010,
    HS_MOD  = 4'b0100,
    HS_DIV  = 4'b1000
  } hash_state_e;

  hash_state_e      state_q, state_d;
  logic [1:0]       phase_q, phase_d;
  logic [1:0]       round_q, round_d;
  logic             done_q, done_d;
  logic [63:0]      val_q, val_d;
  logic [63:0]      acc_q, acc_d;
  logic [63:0]      prod_q, prod_d;
  logic [AddrW-1:0] rem_q, rem_d;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_res;
  logic [63:0] add_sum;
  logic [63:0] post_val;
  logic [31:0] red_sub;

  // A 64x64 product modulo 2^64 is built from three 32x32 partial products:
  // low*low in full, plus the low halves of the two cross terms shifted up.
  always_comb begin
    mul_a = val_q[31:0];
    mul_b = MIX_MUL[31:0];
    unique case (state_q)
      HS_MOD: begin
        mul_a = val_q[63:32];
        mul_b = FoldMul;
      end
      HS_DIV: begin
        if (phase_q == 2'd0) begin
          mul_b = Recip;
        end else begin
          mul_a = prod_q[63:32];
          mul_b = Depth32;
        end
      end
      default: begin
        unique case (phase_q)
          2'd1: begin
            mul_b = MIX_MUL[63:32];
          end
          2'd2: begin
            mul_a = val_q[63:32];
          end
          default: ;
        endcase
      end
    endcase
  end

  assign mul_res = 64'(mul_a) * 64'(mul_b);
  assign add_sum = acc_q + {prod_q[31:0], 32'd0};

  always_comb begin
    unique case (round_q)
      2'd1:    post_val = add_sum ^ MIX_H0;
      default: post_val = add_sum ^ (add_sum >> MIX_SHIFT);
    endcase
  end

  assign red_sub = val_q[31:0] - Depth32;

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    round_d = round_q;
    done_d  = 1'b0;
    val_d   = val_q;
    acc_d   = acc_q;
    prod_d  = prod_q;
    rem_d   = rem_q;
    unique case (state_q)
      HS_IDLE: begin
        if (start_i) begin
          val_d   = key_i;
          phase_d = 2'd0;
          round_d = 2'd0;
          state_d = HS_MUL;
        end
      end
      HS_MUL: begin
        prod_d  = mul_res;
        phase_d = phase_q + 2'd1;
        unique case (phase_q)
          2'd0: ;
          2'd1: acc_d = prod_q;
          2'd2: acc_d = add_sum;
          2'd3: begin
            val_d = post_val;
            if (round_q == 2'd3) begin
              if (IsPow2) begin
                rem_d   = post_val[AddrW-1:0];
                done_d  = 1'b1;
                state_d = HS_IDLE;
              end else begin
                state_d = HS_MOD;
              end
            end else begin
              round_d = round_q + 2'd1;
            end
          end
          default: ;
        endcase
      end
      HS_MOD: begin
        // Fold the upper word down with 2^32 mod depth until the hash fits
        // in 32 bits; this keeps the value congruent.
        if (val_q[63:32] == 32'd0) begin
          phase_d = 2'd0;
          state_d = HS_DIV;
        end else begin
          val_d = mul_res + {32'd0, val_q[31:0]};
        end
      end
      HS_DIV: begin
        // The reciprocal quotient is low by at most one, so a single
        // compare and subtract finishes the remainder.
        phase_d = phase_q + 2'd1;
        unique case (phase_q)
          2'd0, 2'd1: prod_d = mul_res;
          2'd2: val_d = {32'd0, val_q[31:0] - prod_q[31:0]};
          2'd3: begin
            rem_d   = (val_q[31:0] >= Depth32) ? red_sub[AddrW-1:0] : val_q[AddrW-1:0];
            done_d  = 1'b1;
            state_d = HS_IDLE;
          end
          default: ;
        endcase
      end
      default: state_d = HS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= HS_IDLE;
      phase_q <= '0;
      round_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      round_q <= round_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    acc_q  <= acc_d;
    prod_q <= prod_d;
    rem_q  <= rem_d;
  end

  assign done_o = done_q;
  assign slot_o = rem_q;

endmodule

// File: rtl/resident_page_hash_set.sv
// ----------------------------------------------------------------------------
// Resident page hash set
// Open-addressing set of 64-bit page identifiers with linear probing,
// tombstones and a clock scan over the slot table.
// ----------------------------------------------------------------------------
// After reset the block is busy while it writes the empty code into every
// slot of the table, one slot a cycle. A request is taken when start is high
// and busy is low. Insert, contains and remove first run the key through the
// mixer: four 64-bit multiplies on one shared 32x32 multiplier, plus a
// reduction on the same multiplier when TABLE_DEPTH is not a power of two.
// Probing then visits one slot at a time (registered table read, then
// compare), and the single result appears on the following cycle. A reserved
// key answers on the cycle after the request. A clock scan of N slots reads
// one slot at a time and gives one result per slot, each after its registered
// read. Each result is shown for exactly one cycle with result_valid_o high
// and must be captured then: the receiver cannot stall the block. A result
// may still be on the ports in the cycle the next request is taken.
// ----------------------------------------------------------------------------
`include "resident_page_hash_set_assert.svh"

module resident_page_hash_set import rphs_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned MAX_SCAN    = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind_i,
  input  logic [63:0] key_i,
  input  logic [6:0]  scan_count_i,
  output logic        result_valid_o,
  output logic        success_o,
  output logic [63:0] key_out_o,
  output logic        occupied_o,
  output logic        table_full_o,
  output logic        last_o
);

  localparam int unsigned    AddrW    = $clog2(TABLE_DEPTH);
  localparam logic [AddrW-1:0] LastSlot = AddrW'(TABLE_DEPTH - 1);
  localparam logic [6:0]     ScanMax  = 7'(MAX_SCAN);

  typedef enum logic [6:0] {
    ST_CLEAR     = 7'b0000001,
    ST_IDLE      = 7'b0000010,
    ST_HASH      = 7'b0000100,
    ST_PROBE_RD  = 7'b0001000,
    ST_PROBE_CHK = 7'b0010000,
    ST_SCAN_RD   = 7'b0100000,
    ST_SCAN_OUT  = 7'b1000000
  } state_e;

  state_e           state_q, state_d;
  logic [AddrW-1:0] pos_q, pos_d;
  logic [AddrW-1:0] probe_q, probe_d;
  logic [AddrW-1:0] hand_q, hand_d;
  logic [6:0]       left_q, left_d;
  kind_e            kind_q, kind_d;
  logic [63:0]      key_q, key_d;

  logic        res_valid_q, res_valid_d;
  logic        success_q, success_d;
  logic [63:0] key_out_q, key_out_d;
  logic        occupied_q, occupied_d;
  logic        full_q, full_d;
  logic        last_q, last_d;

  logic             ram_we, ram_re;
  logic [63:0]      ram_wdata, ram_rdata;
  logic             hash_start, hash_done;
  logic [AddrW-1:0] hash_slot;
  logic [AddrW-1:0] pos_next;
  logic [6:0]       scan_sat;
  logic             key_reserved, slot_live;
  kind_e            kind_in;

  rphs_ram #(
    .WIDTH (64),
    .DEPTH (TABLE_DEPTH)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pos_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (pos_q),
    .rdata_o (ram_rdata)
  );

  rphs_hash #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start),
    .key_i   (key_i),
    .done_o  (hash_done),
    .slot_o  (hash_slot)
  );

  assign pos_next     = (pos_q == LastSlot) ? '0 : pos_q + AddrW'(1);
  assign kind_in      = kind_e'(kind_i);
  assign key_reserved = (key_i == SLOT_EMPTY) || (key_i == SLOT_TOMB);
  assign slot_live    = (ram_rdata != SLOT_EMPTY) && (ram_rdata != SLOT_TOMB);

  always_comb begin
    if (scan_count_i == 7'd0) begin
      scan_sat = 7'd1;
    end else if (scan_count_i > ScanMax) begin
      scan_sat = ScanMax;
    end else begin
      scan_sat = scan_count_i;
    end
  end

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    probe_d     = probe_q;
    hand_d      = hand_q;
    left_d      = left_q;
    kind_d      = kind_q;
    key_d       = key_q;
    res_valid_d = 1'b0;
    success_d   = success_q;
    key_out_d   = key_out_q;
    occupied_d  = occupied_q;
    full_d      = full_q;
    last_d      = last_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_wdata   = key_q;
    hash_start  = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = SLOT_EMPTY;
        pos_d     = pos_next;
        if (pos_q == LastSlot) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          kind_d = kind_in;
          key_d  = key_i;
          if (kind_in == KIND_SCAN) begin
            pos_d   = hand_q;
            left_d  = scan_sat;
            state_d = ST_SCAN_RD;
          end else if (key_reserved) begin
            res_valid_d = 1'b1;
            success_d   = 1'b0;
            key_out_d   = '0;
            occupied_d  = 1'b0;
            full_d      = 1'b0;
            last_d      = 1'b1;
          end else begin
            hash_start = 1'b1;
            state_d    = ST_HASH;
          end
        end
      end
      ST_HASH: begin
        if (hash_done) begin
          pos_d   = hash_slot;
          probe_d = '0;
          state_d = ST_PROBE_RD;
        end
      end
      ST_PROBE_RD: begin
        ram_re  = 1'b1;
        state_d = ST_PROBE_CHK;
      end
      ST_PROBE_CHK: begin
        key_out_d  = '0;
        occupied_d = 1'b0;
        last_d     = 1'b1;
        success_d  = 1'b0;
        full_d     = 1'b0;
        unique case (kind_q)
          KIND_INSERT: begin
            if (ram_rdata == key_q) begin
              res_valid_d = 1'b1;
              state_d     = ST_IDLE;
            end else if (!slot_live) begin
              // First free slot on the path, empty or tombstone, takes the key.
              ram_we      = 1'b1;
              res_valid_d = 1'b1;
              success_d   = 1'b1;
              state_d     = ST_IDLE;
            end
          end
          KIND_CONTAINS, KIND_REMOVE, KIND_SCAN: begin
            if (ram_rdata == key_q) begin
              if (kind_q == KIND_REMOVE) begin
                ram_we    = 1'b1;
                ram_wdata = SLOT_TOMB;
              end
              res_valid_d = 1'b1;
              success_d   = 1'b1;
              state_d     = ST_IDLE;
            end else if (ram_rdata == SLOT_EMPTY) begin
              res_valid_d = 1'b1;
              state_d     = ST_IDLE;
            end
          end
          default: state_d = ST_IDLE;
        endcase
        if (state_d == ST_PROBE_CHK) begin
          if (probe_q == LastSlot) begin
            // Every slot has been visited without a hit or a stopping slot.
            res_valid_d = 1'b1;
            full_d      = 1'b1;
            state_d     = ST_IDLE;
          end else begin
            pos_d   = pos_next;
            probe_d = probe_q + AddrW'(1);
            state_d = ST_PROBE_RD;
          end
        end
      end
      ST_SCAN_RD: begin
        ram_re  = 1'b1;
        state_d = ST_SCAN_OUT;
      end
      ST_SCAN_OUT: begin
        res_valid_d = 1'b1;
        success_d   = 1'b0;
        key_out_d   = slot_live ? ram_rdata : '0;
        occupied_d  = slot_live;
        full_d      = 1'b0;
        last_d      = (left_q == 7'd1);
        pos_d       = pos_next;
        left_d      = left_q - 7'd1;
        if (left_q == 7'd1) begin
          hand_d  = pos_next;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_SCAN_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      pos_q       <= '0;
      probe_q     <= '0;
      hand_q      <= '0;
      left_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      probe_q     <= probe_d;
      hand_q      <= hand_d;
      left_q      <= left_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    key_q      <= key_d;
    success_q  <= success_d;
    key_out_q  <= key_out_d;
    occupied_q <= occupied_d;
    full_q     <= full_d;
    last_q     <= last_d;
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = res_valid_q;
  assign success_o      = success_q;
  assign key_out_o      = key_out_q;
  assign occupied_o     = occupied_q;
  assign table_full_o   = full_q;
  assign last_o         = last_q;

  `RPHS_ASSERT_IMPLY(a_no_result_in_clear, state_q == ST_CLEAR, !res_valid_q, "result during clearing pass")
  `RPHS_ASSERT_NEXT(a_request_progress, start && !busy, busy || result_valid_o, "request taken without progress")
  `RPHS_ASSERT_IMPLY(a_hand_in_range, 1'b1, hand_q <= LastSlot, "clock hand beyond table")
  `RPHS_ASSERT_IMPLY(a_full_is_final, result_valid_o && table_full_o, last_o && !success_o && !occupied_o, "full result malformed")
  `RPHS_ASSERT_IMPLY(a_tomb_only_on_remove, ram_we && (ram_wdata == SLOT_TOMB), kind_q == KIND_REMOVE, "tombstone written outside remove")

endmodule
